[hw/rtl/segment_font_pixel_generator_top_defines.svh]
// Assertion helpers for the segment font pixel generator.
`ifndef SEGMENT_FONT_PIXEL_GENERATOR_TOP_DEFINES_SVH
`define SEGMENT_FONT_PIXEL_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define SFPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfpg assertion failed");
`define SFPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfpg assertion failed");
`else
`define SFPG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SFPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/sfpg_pkg.sv]
`default_nettype none

package sfpg_pkg;

    localparam int NUM_SEGS = 14;

    localparam logic [NUM_SEGS-1:0] SEG_A  = 14'h0001;
    localparam logic [NUM_SEGS-1:0] SEG_B  = 14'h0002;
    localparam logic [NUM_SEGS-1:0] SEG_C  = 14'h0004;
    localparam logic [NUM_SEGS-1:0] SEG_D  = 14'h0008;
    localparam logic [NUM_SEGS-1:0] SEG_E  = 14'h0010;
    localparam logic [NUM_SEGS-1:0] SEG_F  = 14'h0020;
    localparam logic [NUM_SEGS-1:0] SEG_G1 = 14'h0040;
    localparam logic [NUM_SEGS-1:0] SEG_G2 = 14'h0080;
    localparam logic [NUM_SEGS-1:0] SEG_H  = 14'h0100;
    localparam logic [NUM_SEGS-1:0] SEG_I  = 14'h0200;
    localparam logic [NUM_SEGS-1:0] SEG_J  = 14'h0400;
    localparam logic [NUM_SEGS-1:0] SEG_K  = 14'h0800;
    localparam logic [NUM_SEGS-1:0] SEG_L  = 14'h1000;
    localparam logic [NUM_SEGS-1:0] SEG_M  = 14'h2000;

    typedef enum logic [2:0] {
        REG_SCALE  = 3'd0,
        REG_FG     = 3'd1,
        REG_BG     = 3'd2,
        REG_OPAQUE = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic        [7:0] char_code;
        logic signed [7:0] col_offset;
        logic signed [7:0] row_offset;
    } in_t;

    typedef struct packed {
        logic        write_pixel;
        logic [31:0] pixel_value;
    } out_t;

    function automatic logic [NUM_SEGS-1:0] char_mask(input logic [7:0] code);
        logic [7:0]          c;
        logic [NUM_SEGS-1:0] m;
        c = code;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            c = c - 8'd32;
        end
        case (c)
            8'h30: m = SEG_A|SEG_B|SEG_C|SEG_D|SEG_E|SEG_F|SEG_M;
            8'h31: m = SEG_B|SEG_C;
            8'h32: m = SEG_A|SEG_B|SEG_G1|SEG_G2|SEG_E|SEG_D;
            8'h33: m = SEG_A|SEG_B|SEG_G1|SEG_G2|SEG_C|SEG_D;
            8'h34: m = SEG_F|SEG_B|SEG_G1|SEG_G2|SEG_C;
            8'h35: m = SEG_A|SEG_F|SEG_G1|SEG_G2|SEG_C|SEG_D;
            8'h36: m = SEG_A|SEG_F|SEG_G1|SEG_G2|SEG_E|SEG_C|SEG_D;
            8'h37: m = SEG_A|SEG_B|SEG_C;
            8'h38: m = SEG_A|SEG_B|SEG_C|SEG_D|SEG_E|SEG_F|SEG_G1|SEG_G2;
            8'h39: m = SEG_A|SEG_F|SEG_B|SEG_G1|SEG_G2|SEG_C|SEG_D;
            8'h41: m = SEG_A|SEG_B|SEG_C|SEG_E|SEG_F|SEG_G1|SEG_G2;
            8'h42: m = SEG_A|SEG_B|SEG_C|SEG_D|SEG_I|SEG_L|SEG_G1|SEG_G2;
            8'h43: m = SEG_A|SEG_F|SEG_E|SEG_D;
            8'h44: m = SEG_A|SEG_B|SEG_C|SEG_D|SEG_I|SEG_L;
            8'h45: m = SEG_A|SEG_F|SEG_E|SEG_D|SEG_G1|SEG_G2;
            8'h46: m = SEG_A|SEG_F|SEG_E|SEG_G1|SEG_G2;
            8'h47: m = SEG_A|SEG_F|SEG_E|SEG_D|SEG_C|SEG_G2;
            8'h48: m = SEG_B|SEG_C|SEG_E|SEG_F|SEG_G1|SEG_G2;
            8'h49: m = SEG_A|SEG_D|SEG_I|SEG_L;
            8'h4A: m = SEG_B|SEG_C|SEG_D|SEG_E;
            8'h4B: m = SEG_F|SEG_E|SEG_H|SEG_K|SEG_M;
            8'h4C: m = SEG_F|SEG_E|SEG_D;
            8'h4D: m = SEG_F|SEG_E|SEG_B|SEG_C|SEG_H|SEG_J;
            8'h4E: m = SEG_F|SEG_E|SEG_B|SEG_C|SEG_H|SEG_M;
            8'h4F: m = SEG_A|SEG_B|SEG_C|SEG_D|SEG_E|SEG_F;
            8'h50: m = SEG_A|SEG_F|SEG_E|SEG_B|SEG_G1|SEG_G2;
            8'h51: m = SEG_A|SEG_B|SEG_C|SEG_D|SEG_E|SEG_F|SEG_M;
            8'h52: m = SEG_A|SEG_F|SEG_E|SEG_B|SEG_G1|SEG_G2|SEG_M;
            8'h53: m = SEG_A|SEG_F|SEG_G1|SEG_G2|SEG_C|SEG_D;
            8'h54: m = SEG_A|SEG_I|SEG_L;
            8'h55: m = SEG_B|SEG_C|SEG_D|SEG_E|SEG_F;
            8'h56: m = SEG_F|SEG_B|SEG_K|SEG_M;
            8'h57: m = SEG_F|SEG_E|SEG_B|SEG_C|SEG_K|SEG_M;
            8'h58: m = SEG_H|SEG_J|SEG_K|SEG_M;
            8'h59: m = SEG_H|SEG_J|SEG_L;
            8'h5A: m = SEG_A|SEG_D|SEG_H|SEG_M;
            8'h3A: m = SEG_I|SEG_L;
            8'h2D: m = SEG_G1|SEG_G2;
            8'h2E: m = SEG_D;
            8'h2F: m = SEG_K|SEG_J;
            8'h5F: m = SEG_D;
            8'h25: m = SEG_H|SEG_M|SEG_K|SEG_J;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/segment_font_pixel_generator_top.sv]
// Fourteen-segment text overlay, one pixel per request.
// Input channel (in_valid / in_stall / in_data): character code plus signed
// column and row offset from the glyph cell's top-left corner.
// Output channel (out_valid / out_stall / out_data): one result per request,
// write_pixel and the color to write (zero when nothing is written).
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// index 0 scale, 1 foreground, 2 background, 3 opaque flag, others ignored.
// Write config only while no request is in flight.
// A request is captured in the input register, evaluated in one combinational
// pass and lands in the output register. Throughput: one request per clock
// while the receiver does not stall, set by that single pass.
// When the receiver stalls, the output register holds; the input register
// takes one more request only if it is empty, and in_stall is high while it
// holds a request that cannot move on.
// Reset: both stages empty, scale 1, foreground all ones, background zero,
// opaque off.
`default_nettype none

`include "segment_font_pixel_generator_top_defines.svh"

module segment_font_pixel_generator_top #(
    parameter int MAX_SCALE = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output      logic          in_stall,
    input  wire sfpg_pkg::in_t in_data,
    output      logic          out_valid,
    input  wire logic          out_stall,
    output      sfpg_pkg::out_t out_data,
    input  wire logic          cfg_valid,
    output      logic          cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);
    import sfpg_pkg::*;

    localparam int SW = $clog2(MAX_SCALE + 1);
    localparam int CW = $clog2(128 + 8 * MAX_SCALE) + 2;
    localparam int IW = $clog2(3 * MAX_SCALE + 1);
    localparam int PW = IW + 12;
    localparam int RECIP3 = 683;
    localparam int RSHIFT = 11;

    typedef logic signed [CW-1:0] coord_t;

    logic [SW-1:0]  scale_reg;
    logic [31:0]    fg_reg;
    logic [31:0]    bg_reg;
    logic           opaque_reg;

    in_t            in_reg;
    logic           s1_valid_reg;
    out_t           out_reg;
    logic           out_valid_reg;
    out_t           out_next;

    logic           adv;
    logic           in_take;
    logic [4:0]     cfg_scale_raw;

    coord_t x, y, s, h, s2, s3, s4, s6, s8;
    logic [NUM_SEGS-1:0] mask;
    logic [NUM_SEGS-1:0] hit;
    logic           lit;
    logic           in_cell;

    // floor(n / 3) for n = 2*i, n small enough for the reciprocal to be exact
    function automatic logic [IW-1:0] third(input logic [IW:0] n);
        logic [PW-1:0] prod;
        prod = PW'(n) * PW'(RECIP3);
        return IW'(prod >> RSHIFT);
    endfunction

    function automatic logic line_cover(input coord_t across, input coord_t along,
                                        input coord_t lo, input coord_t hi,
                                        input coord_t hw);
        return (across >= -hw) && (across <= hw) &&
               (along >= lo - hw) && (along <= hi + hw);
    endfunction

    // diagonal of 3s rows; column advances floor(2i/3) on row i
    function automatic logic diag_cover(input coord_t u, input coord_t v,
                                        input coord_t s3v, input coord_t hw);
        coord_t        ilo;
        coord_t        ihi;
        logic [IW-1:0] flo;
        logic [IW-1:0] fhi;
        ilo = u - hw;
        ihi = u + hw;
        if (ilo < 0)
        begin
            ilo = '0;
        end
        if (ihi > s3v)
        begin
            ihi = s3v;
        end
        flo = third({IW'(ilo), 1'b0});
        fhi = third({IW'(ihi), 1'b0});
        return (ilo <= ihi) &&
               (v >= $signed({{(CW-IW){1'b0}}, flo}) - hw) &&
               (v <= $signed({{(CW-IW){1'b0}}, fhi}) + hw);
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_scale_raw = cfg_data[4:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SW'(1);
            fg_reg     <= 32'hFFFF_FFFF;
            bg_reg     <= '0;
            opaque_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCALE:
                begin
                    // zero acts as one, large values saturate
                    if (cfg_scale_raw == 5'd0)
                    begin
                        scale_reg <= SW'(1);
                    end
                    else if (int'(cfg_scale_raw) > MAX_SCALE)
                    begin
                        scale_reg <= SW'(MAX_SCALE);
                    end
                    else
                    begin
                        scale_reg <= SW'(cfg_scale_raw);
                    end
                end
                REG_FG:     fg_reg     <= cfg_data;
                REG_BG:     bg_reg     <= cfg_data;
                REG_OPAQUE: opaque_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= in_data;
        end
        if (adv && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        x    = CW'(in_reg.col_offset);
        y    = CW'(in_reg.row_offset);
        s    = $signed({{(CW-SW){1'b0}}, scale_reg});
        h    = s >>> 1;
        s2   = s <<< 1;
        s4   = s <<< 2;
        s8   = s <<< 3;
        s3   = s2 + s;
        s6   = s4 + s2;
        mask = char_mask(in_reg.char_code);

        hit[0]  = line_cover(y,      x, '0, s4, h);
        hit[1]  = line_cover(x - s4, y, '0, s3, h);
        hit[2]  = line_cover(x - s4, y, s3, s6, h);
        hit[3]  = line_cover(y - s6, x, '0, s4, h);
        hit[4]  = line_cover(x,      y, s3, s6, h);
        hit[5]  = line_cover(x,      y, '0, s3, h);
        hit[6]  = line_cover(y - s3, x, '0, s2, h);
        hit[7]  = line_cover(y - s3, x, s2, s4, h);
        hit[8]  = diag_cover(y,      x,      s3, h);
        hit[9]  = line_cover(x - s2, y, '0, s3, h);
        hit[10] = diag_cover(y,      s4 - x, s3, h);
        hit[11] = diag_cover(s6 - y, x,      s3, h);
        hit[12] = line_cover(x - s2, y, s3, s6, h);
        hit[13] = diag_cover(s6 - y, s4 - x, s3, h);

        lit     = |(hit & mask);
        in_cell = (x >= 0) && (y >= 0) && (x < s6) && (y < s8);

        if (lit)
        begin
            out_next.write_pixel = 1'b1;
            out_next.pixel_value = fg_reg;
        end
        else if (opaque_reg && in_cell)
        begin
            out_next.write_pixel = 1'b1;
            out_next.pixel_value = bg_reg;
        end
        else
        begin
            out_next.write_pixel = 1'b0;
            out_next.pixel_value = '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SFPG_ASSERT_NEXT(a_take_fills_s1, clk, rst_n, in_take, s1_valid_reg)
    `SFPG_ASSERT_NEXT(a_s1_moves_out, clk, rst_n, s1_valid_reg && adv, out_valid_reg)
    `SFPG_ASSERT_SAME(a_no_write_zero, clk, rst_n, out_valid_reg && !out_reg.write_pixel,
                      out_reg.pixel_value == 32'd0)
    `SFPG_ASSERT_SAME(a_scale_range, clk, rst_n, 1'b1,
                      scale_reg != '0 && int'(scale_reg) <= MAX_SCALE)

endmodule

`default_nettype wire
